### sv/nmea_rmc_sentence_parser_core_macros.svh
// ----------------------------------------------------------------------------
// nmea rmc parser assertion macros
// shared property wrappers, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef NMEA_RMC_SENTENCE_PARSER_CORE_MACROS_SVH
`define NMEA_RMC_SENTENCE_PARSER_CORE_MACROS_SVH

// combinational or implication property checked at every edge
`define NRSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition at one edge implies another at the next edge
`define NRSP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### sv/nrsp_pkg.sv
// ----------------------------------------------------------------------------
// nmea rmc parser package
// character codes, field positions, register map and speed scaling constants
// ----------------------------------------------------------------------------
package nrsp_pkg;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [3:0] FLD_TIME   = 4'd1;
    localparam logic [3:0] FLD_STATUS = 4'd2;
    localparam logic [3:0] FLD_LAT    = 4'd3;
    localparam logic [3:0] FLD_LON    = 4'd5;
    localparam logic [3:0] FLD_SPEED  = 4'd7;
    localparam logic [3:0] FLD_COURSE = 4'd8;
    localparam logic [3:0] FLD_DATE   = 4'd9;

    localparam logic [0:0] REG_SPEED_FACTOR = 1'b0;
    localparam logic [15:0] SPEED_FACTOR_RESET = 16'd1825;

    localparam logic [30:0] POS_MAX    = 31'h7FFF_FFFF;
    localparam logic [31:0] COURSE_MAX = 32'd999;

    // divide by 1e6 as a shift by 6 and a reciprocal multiply for 15625
    localparam int unsigned  SPD_PRE_SHIFT = 6;
    localparam int unsigned  SPD_SHIFT     = 44;
    localparam logic [63:0]  SPD_DIV       = 64'd15625;
    localparam logic [63:0]  SPD_RECIP_64  =
        ((64'd1 << SPD_SHIFT) + SPD_DIV - 64'd1) / SPD_DIV;
    localparam logic [30:0]  SPD_RECIP     = SPD_RECIP_64[30:0];
    localparam logic [47:0]  SPD_SAT_LIMIT = 48'd65536 * 48'd1000000;

    typedef struct packed {
        logic        status;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic [7:0]  day;
        logic [7:0]  month;
        logic [7:0]  year;
        logic [30:0] lat;
        logic [30:0] lon;
        logic [9:0]  course;
    } snap_t;

    function automatic logic [31:0] sat_push(input logic [31:0] a, input logic [3:0] d);
        logic [35:0] t;
        t = ({4'd0, a} << 3) + ({4'd0, a} << 1) + {32'd0, d};
        return (t[35:32] != 4'd0) ? 32'hFFFF_FFFF : t[31:0];
    endfunction

endpackage

### sv/nmea_rmc_sentence_parser_core.sv
// ----------------------------------------------------------------------------
// nmea rmc sentence parser core
// Takes one sentence character per cycle on the slave stream and keeps the
// last committed RMC time, date, position, speed and course. A newline puts
// out one result item with all held values and the void flag in tuser. The
// input accepts an item every cycle but while stalled; a result passes the
// snapshot registers and the output register after its newline, in step
// with the three-stage speed scaling pipeline (32x16 multiply, reciprocal
// multiply for the divide by 1e6, then the speed register). Input stalls only
// while a result is ready behind an output item that is not taken.
// ----------------------------------------------------------------------------
`include "nmea_rmc_sentence_parser_core_macros.svh"

module nmea_rmc_sentence_parser_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // hour_bcd, minute_bcd, second_bcd, day_bcd,
                                    // month_bcd, year_bcd, latitude_digits,
                                    // longitude_digits, speed_value, course_degrees
    output logic [0:0]   m_tuser,   // [0] status
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [15:0] speed_factor_reg;

    logic [3:0]  field_number_reg, field_number_next;
    logic [3:0]  char_position_reg, char_position_next;
    logic [31:0] acc_reg, acc_next;
    logic        after_point_reg, after_point_next;
    logic [1:0]  fraction_count_reg, fraction_count_next;
    logic        has_digit_reg, has_digit_next;
    logic        void_seen_reg, void_seen_next;

    logic [7:0]  hour_reg, hour_next;
    logic [7:0]  minute_reg, minute_next;
    logic [7:0]  second_reg, second_next;
    logic [7:0]  day_reg, day_next;
    logic [7:0]  month_reg, month_next;
    logic [7:0]  year_reg, year_next;
    logic [30:0] lat_reg, lat_next;
    logic [30:0] lon_reg, lon_next;
    logic [9:0]  course_reg, course_next;
    logic [15:0] speed_reg;

    logic        spd_h_valid_reg;
    logic [31:0] spd_h_reg;
    logic        spd_p_valid_reg;
    logic [47:0] spd_p_reg;
    logic        spd_q_valid_reg;
    logic        spd_sat_reg;
    logic [60:0] spd_q_reg;

    logic              snap1_valid_reg, snap2_valid_reg, snap3_valid_reg;
    nrsp_pkg::snap_t   snap1_reg, snap2_reg, snap3_reg, snap_now;

    logic              m_valid_reg;
    nrsp_pkg::snap_t   out_snap_reg;
    logic [15:0]       out_speed_reg;

    logic        in_accept;
    logic        out_load;
    logic        adv;
    logic        launch;
    logic        snap_take;
    logic        is_digit;
    logic [3:0]  digit;
    logic [4:0]  bcd_shift;
    logic [38:0] acc_x100;
    logic [31:0] spd_h_in;
    logic [47:0] spd_product;
    logic [60:0] spd_recip_product;
    logic        cfg_write;

    // output register and pipeline advance
    assign out_load  = !m_valid_reg || m_tready;
    assign adv       = out_load || !snap3_valid_reg;
    assign s_tready  = adv;
    assign in_accept = s_tvalid && adv;

    assign is_digit  = (s_tdata >= nrsp_pkg::CH_ZERO) && (s_tdata <= nrsp_pkg::CH_NINE);
    assign digit     = is_digit ? s_tdata[3:0] : 4'd0;
    assign bcd_shift = 5'd20 - {char_position_reg[2:0], 2'b00};

    // pad speed to hundredths
    assign acc_x100 = {7'd0, acc_reg} * 39'd100;
    always_comb
    begin
        if (fraction_count_reg[1])
        begin
            spd_h_in = acc_reg;
        end
        else if (fraction_count_reg[0])
        begin
            spd_h_in = nrsp_pkg::sat_push(acc_reg, 4'd0);
        end
        else
        begin
            spd_h_in = (acc_x100[38:32] != 7'd0) ? 32'hFFFF_FFFF : acc_x100[31:0];
        end
    end

    always_comb
    begin
        field_number_next   = field_number_reg;
        char_position_next  = char_position_reg;
        acc_next            = acc_reg;
        after_point_next    = after_point_reg;
        fraction_count_next = fraction_count_reg;
        has_digit_next      = has_digit_reg;
        void_seen_next      = void_seen_reg;
        hour_next           = hour_reg;
        minute_next         = minute_reg;
        second_next         = second_reg;
        day_next            = day_reg;
        month_next          = month_reg;
        year_next           = year_reg;
        lat_next            = lat_reg;
        lon_next            = lon_reg;
        course_next         = course_reg;
        launch              = 1'b0;
        snap_take           = 1'b0;

        if (in_accept)
        begin
            if (s_tdata == nrsp_pkg::CH_DOLLAR || s_tdata == nrsp_pkg::CH_NEWLINE)
            begin
                snap_take           = (s_tdata == nrsp_pkg::CH_NEWLINE);
                field_number_next   = 4'd0;
                void_seen_next      = 1'b0;
                char_position_next  = 4'd0;
                acc_next            = 32'd0;
                after_point_next    = 1'b0;
                fraction_count_next = 2'd0;
                has_digit_next      = 1'b0;
            end
            else if (s_tdata == nrsp_pkg::CH_COMMA)
            begin
                if (field_number_reg == nrsp_pkg::FLD_TIME)
                begin
                    if (has_digit_reg)
                    begin
                        hour_next   = acc_reg[23:16];
                        minute_next = acc_reg[15:8];
                        second_next = acc_reg[7:0];
                    end
                end
                else if (field_number_reg == nrsp_pkg::FLD_STATUS)
                begin
                    if (char_position_reg == 4'd0 || acc_reg != {24'd0, nrsp_pkg::CH_A})
                    begin
                        void_seen_next = 1'b1;
                    end
                end
                else if (!void_seen_reg && has_digit_reg)
                begin
                    case (field_number_reg)
                        nrsp_pkg::FLD_LAT:
                            lat_next = acc_reg[31] ? nrsp_pkg::POS_MAX : acc_reg[30:0];
                        nrsp_pkg::FLD_LON:
                            lon_next = acc_reg[31] ? nrsp_pkg::POS_MAX : acc_reg[30:0];
                        nrsp_pkg::FLD_SPEED:
                            launch = 1'b1;
                        nrsp_pkg::FLD_COURSE:
                            course_next = (acc_reg > nrsp_pkg::COURSE_MAX) ?
                                          nrsp_pkg::COURSE_MAX[9:0] : acc_reg[9:0];
                        nrsp_pkg::FLD_DATE:
                        begin
                            day_next   = acc_reg[23:16];
                            month_next = acc_reg[15:8];
                            year_next  = acc_reg[7:0];
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (field_number_reg != 4'hF)
                begin
                    field_number_next = field_number_reg + 4'd1;
                end
                char_position_next  = 4'd0;
                acc_next            = 32'd0;
                after_point_next    = 1'b0;
                fraction_count_next = 2'd0;
                has_digit_next      = 1'b0;
            end
            else
            begin
                case (field_number_reg)
                    nrsp_pkg::FLD_TIME, nrsp_pkg::FLD_DATE:
                    begin
                        if (char_position_reg < 4'd6)
                        begin
                            acc_next = acc_reg | ({28'd0, digit} << bcd_shift);
                            if (is_digit)
                            begin
                                has_digit_next = 1'b1;
                            end
                        end
                    end
                    nrsp_pkg::FLD_STATUS:
                    begin
                        if (char_position_reg == 4'd0)
                        begin
                            acc_next = {24'd0, s_tdata};
                        end
                    end
                    nrsp_pkg::FLD_LAT, nrsp_pkg::FLD_LON:
                    begin
                        if (is_digit)
                        begin
                            acc_next       = nrsp_pkg::sat_push(acc_reg, digit);
                            has_digit_next = 1'b1;
                        end
                    end
                    nrsp_pkg::FLD_SPEED:
                    begin
                        if (s_tdata == nrsp_pkg::CH_POINT)
                        begin
                            after_point_next = 1'b1;
                        end
                        else if (is_digit)
                        begin
                            has_digit_next = 1'b1;
                            if (!after_point_reg)
                            begin
                                acc_next = nrsp_pkg::sat_push(acc_reg, digit);
                            end
                            else if (fraction_count_reg < 2'd2)
                            begin
                                acc_next            = nrsp_pkg::sat_push(acc_reg, digit);
                                fraction_count_next = fraction_count_reg + 2'd1;
                            end
                        end
                    end
                    nrsp_pkg::FLD_COURSE:
                    begin
                        if (s_tdata == nrsp_pkg::CH_POINT)
                        begin
                            after_point_next = 1'b1;
                        end
                        else if (is_digit && !after_point_reg)
                        begin
                            acc_next       = nrsp_pkg::sat_push(acc_reg, digit);
                            has_digit_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (char_position_reg != 4'hF)
                begin
                    char_position_next = char_position_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_number_reg   <= 4'd0;
            char_position_reg  <= 4'd0;
            acc_reg            <= 32'd0;
            after_point_reg    <= 1'b0;
            fraction_count_reg <= 2'd0;
            has_digit_reg      <= 1'b0;
            void_seen_reg      <= 1'b0;
            hour_reg           <= 8'd0;
            minute_reg         <= 8'd0;
            second_reg         <= 8'd0;
            day_reg            <= 8'd0;
            month_reg          <= 8'd0;
            year_reg           <= 8'd0;
            lat_reg            <= 31'd0;
            lon_reg            <= 31'd0;
            course_reg         <= 10'd0;
        end
        else
        begin
            field_number_reg   <= field_number_next;
            char_position_reg  <= char_position_next;
            acc_reg            <= acc_next;
            after_point_reg    <= after_point_next;
            fraction_count_reg <= fraction_count_next;
            has_digit_reg      <= has_digit_next;
            void_seen_reg      <= void_seen_next;
            hour_reg           <= hour_next;
            minute_reg         <= minute_next;
            second_reg         <= second_next;
            day_reg            <= day_next;
            month_reg          <= month_next;
            year_reg           <= year_next;
            lat_reg            <= lat_next;
            lon_reg            <= lon_next;
            course_reg         <= course_next;
        end
    end

    // speed scaling pipeline
    assign spd_product       = {16'd0, spd_h_reg} * {32'd0, speed_factor_reg};
    assign spd_recip_product = {31'd0, spd_p_reg[nrsp_pkg::SPD_PRE_SHIFT +: 30]} *
                               {30'd0, nrsp_pkg::SPD_RECIP};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spd_h_valid_reg <= 1'b0;
            spd_p_valid_reg <= 1'b0;
            spd_q_valid_reg <= 1'b0;
            speed_reg       <= 16'd0;
        end
        else if (adv)
        begin
            spd_h_valid_reg <= launch;
            spd_p_valid_reg <= spd_h_valid_reg;
            spd_q_valid_reg <= spd_p_valid_reg;
            if (spd_q_valid_reg)
            begin
                speed_reg <= spd_sat_reg ? 16'hFFFF :
                             spd_q_reg[nrsp_pkg::SPD_SHIFT +: 16];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (launch)
            begin
                spd_h_reg <= spd_h_in;
            end
            if (spd_h_valid_reg)
            begin
                spd_p_reg <= spd_product;
            end
            if (spd_p_valid_reg)
            begin
                spd_sat_reg <= (spd_p_reg >= nrsp_pkg::SPD_SAT_LIMIT);
                spd_q_reg   <= spd_recip_product;
            end
        end
    end

    // held values wait beside the speed pipeline
    always_comb
    begin
        snap_now.status = void_seen_reg;
        snap_now.hour   = hour_reg;
        snap_now.minute = minute_reg;
        snap_now.second = second_reg;
        snap_now.day    = day_reg;
        snap_now.month  = month_reg;
        snap_now.year   = year_reg;
        snap_now.lat    = lat_reg;
        snap_now.lon    = lon_reg;
        snap_now.course = course_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap1_valid_reg <= 1'b0;
            snap2_valid_reg <= 1'b0;
            snap3_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                snap1_valid_reg <= snap_take;
                snap2_valid_reg <= snap1_valid_reg;
                snap3_valid_reg <= snap2_valid_reg;
            end
            if (out_load)
            begin
                m_valid_reg <= snap3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            snap1_reg <= snap_now;
            snap2_reg <= snap1_reg;
            snap3_reg <= snap2_reg;
        end
        if (out_load && snap3_valid_reg)
        begin
            out_snap_reg  <= snap3_reg;
            out_speed_reg <= speed_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_snap_reg.status;
    assign m_tdata  = {out_snap_reg.course, out_speed_reg, out_snap_reg.lon,
                       out_snap_reg.lat, out_snap_reg.year, out_snap_reg.month,
                       out_snap_reg.day, out_snap_reg.second, out_snap_reg.minute,
                       out_snap_reg.hour};

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_factor_reg <= nrsp_pkg::SPEED_FACTOR_RESET;
        end
        else if (cfg_write && paddr[2] == nrsp_pkg::REG_SPEED_FACTOR)
        begin
            speed_factor_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == nrsp_pkg::REG_SPEED_FACTOR) ?
                    {16'd0, speed_factor_reg} : 32'd0;

    // checks
    `NRSP_ASSERT(a_one_speed_in_flight,
        $onehot0({spd_h_valid_reg, spd_p_valid_reg, spd_q_valid_reg}),
        "more than one speed commit in flight")
    `NRSP_ASSERT_NEXT(a_newline_enters_line,
        s_tvalid && s_tready && s_tdata == nrsp_pkg::CH_NEWLINE,
        snap1_valid_reg,
        "accepted newline did not start a result")
    `NRSP_ASSERT(a_stall_only_on_blocked_output,
        !s_tready |-> (m_tvalid && !m_tready),
        "input stalled without a blocked output item")

endmodule
